[rtl/joystick_deadzone_quantizer_top_assert.svh]
// ============================================================================
// Assertion macros for the joystick dead-zone quantizer
// Shared concurrent-assertion templates, synchronous reset disables them.
// ============================================================================
`ifndef JOYSTICK_DEADZONE_QUANTIZER_TOP_ASSERT_SVH
`define JOYSTICK_DEADZONE_QUANTIZER_TOP_ASSERT_SVH

// same-cycle implication
`define JDQ_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define JDQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/jdq_pkg.sv]
// ============================================================================
// jdq_pkg
// Types and fixed constants of the joystick dead-zone quantizer.
// ============================================================================
package jdq_pkg;

   localparam int SAMPLE_W = 12;  // raw sample field width
   localparam int MARGIN_W = 10;  // dead_margin register width
   localparam int CODE_W   = 4;   // per-axis code width
   localparam int QUO_W    = 3;   // quotient bits, every quotient is below 8
   localparam int STEP_W   = 2;   // divide step counter width
   localparam int PACK_W   = 2 * CODE_W;

   localparam int LOW_SCALE  = 6;
   localparam int HIGH_SCALE = 7;

   localparam logic [MARGIN_W-1:0] MARGIN_RESET = 10'd50;
   localparam logic [CODE_W-1:0]   DEAD_CODE    = 4'd7;

   // command bit of an input word
   localparam logic CMD_CAL = 1'b0;
   localparam logic CMD_RUN = 1'b1;

   // axis select
   localparam logic AXIS_X = 1'b0;
   localparam logic AXIS_Y = 1'b1;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SETUP  = 5'b00010,
      ST_DIVIDE = 5'b00100,
      ST_STORE  = 5'b01000,
      ST_DECIDE = 5'b10000
   } jdq_state_type;

   typedef struct packed {
      logic              capture;    // latch samples of the accepted word
      logic              calibrate;  // widen rest bands from the input ports
      logic              setup;      // pick branch, load numerator/divisor
      logic              axis;       // axis for setup and store
      logic              divide;     // one restoring divide step
      logic [STEP_W-1:0] shift;      // quotient bit position of this step
      logic              store;      // write finished code of axis
      logic              emit;       // load output word, update previous codes
   } jdq_cmd_type;

   typedef struct packed {
      logic changed;  // current codes differ from previous run codes
   } jdq_status_type;

endpackage

[rtl/jdq_ctrl.sv]
// ============================================================================
// jdq_ctrl
// Sequencer: handshakes, per-axis divide sequencing and output valid.
// ============================================================================
`include "joystick_deadzone_quantizer_top_assert.svh"

module jdq_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_cmd,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output jdq_pkg::jdq_cmd_type    dp_cmd,
   input  jdq_pkg::jdq_status_type dp_status
);
   import jdq_pkg::*;

   jdq_state_type     state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              axis_ff, axis_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      axis_in  = axis_ff;
      dp_cmd   = '0;
      dp_cmd.axis  = axis_ff;
      dp_cmd.shift = step_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               dp_cmd.capture = 1'b1;
               if (req_cmd == CMD_RUN) begin
                  axis_in  = AXIS_X;
                  state_in = ST_SETUP;
               end else begin
                  dp_cmd.calibrate = 1'b1;
               end
            end
         end
         ST_SETUP: begin
            dp_cmd.setup = 1'b1;
            step_in  = STEP_W'(QUO_W - 1);
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            dp_cmd.divide = 1'b1;
            if (step_ff == '0) begin
               state_in = ST_STORE;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         ST_STORE: begin
            dp_cmd.store = 1'b1;
            if (axis_ff == AXIS_Y) begin
               state_in = ST_DECIDE;
            end else begin
               axis_in  = AXIS_Y;
               state_in = ST_SETUP;
            end
         end
         ST_DECIDE: begin
            if (!dp_status.changed) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               dp_cmd.emit = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (dp_cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         axis_ff      <= AXIS_X;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         axis_ff      <= axis_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `JDQ_ASSERT_NEXT(a_run_starts_x, clock, reset,
      req_valid && req_ready && (req_cmd == CMD_RUN),
      (state_ff == ST_SETUP) && (axis_ff == AXIS_X), "run word did not start x axis")
   `JDQ_ASSERT_SAME(a_emit_only_changed, clock, reset,
      dp_cmd.emit, dp_status.changed, "emit without a code change")
   `JDQ_ASSERT_SAME(a_emit_slot_free, clock, reset,
      dp_cmd.emit, out_free, "emit would overwrite a pending word")
   `JDQ_ASSERT_NEXT(a_divide_ends, clock, reset,
      (state_ff == ST_DIVIDE) && (step_ff == '0), state_ff == ST_STORE,
      "divide did not end after last step")

endmodule

[rtl/jdq_datapath.sv]
// ============================================================================
// jdq_datapath
// Rest bands, margin, branch select, shared 3-bit restoring divider, codes.
// ============================================================================
module jdq_datapath #(
   parameter int ADC_BITS = 12
) (
   input  logic                            clock,
   input  logic                            reset,
   input  jdq_pkg::jdq_cmd_type            dp_cmd,
   input  logic [jdq_pkg::SAMPLE_W-1:0]    req_x_sample,
   input  logic [jdq_pkg::SAMPLE_W-1:0]    req_y_sample,
   input  logic                            csr_wr_en,
   input  logic [jdq_pkg::MARGIN_W-1:0]    csr_wr_data,
   output jdq_pkg::jdq_status_type         dp_status,
   output logic [jdq_pkg::PACK_W-1:0]      rsp_packed_code
);
   import jdq_pkg::*;

   localparam int SW = ADC_BITS;
   localparam int CW = (SW > SAMPLE_W) ? SW : SAMPLE_W;   // clamp compare width
   localparam int EW = ((SW > MARGIN_W) ? SW : MARGIN_W) + 1;  // sum width, no wrap
   localparam int NW = SW + 3;                            // numerator width
   localparam logic [SW-1:0] FULL = {SW{1'b1}};

   function automatic logic [SW-1:0] clamp(input logic [SAMPLE_W-1:0] raw);
      logic [CW-1:0] wide;
      wide = CW'(raw);
      if (wide > CW'(FULL)) begin
         clamp = FULL;
      end else begin
         clamp = wide[SW-1:0];
      end
   endfunction

   logic [MARGIN_W-1:0] margin_ff;
   logic [SW-1:0]       x_low_ff, x_high_ff, y_low_ff, y_high_ff;
   logic [SW-1:0]       x_s_ff, y_s_ff;
   logic [CODE_W-1:0]   x_code_ff, y_code_ff;
   logic [CODE_W-1:0]   prev_x_ff, prev_y_ff;
   logic [PACK_W-1:0]   rsp_packed_code_ff;
   logic [NW-1:0]       rem_ff, rem_in;
   logic [SW-1:0]       den_ff, den_in;
   logic [QUO_W-1:0]    quo_ff;
   logic                hi_ff, hi_in;
   logic                dz_ff, dz_in;

   logic [SW-1:0] x_clamp, y_clamp;
   logic [SW-1:0] s_sel, low_sel, high_sel;
   logic [EW-1:0] s_plus_m, edge_sum, low_minus, hi_span, hi_off;
   logic          lo_hit, hi_hit;
   logic [NW-1:0] lo_num, hi_num, trial;
   logic          ge;
   logic [CODE_W-1:0] code;

   assign x_clamp = clamp(req_x_sample);
   assign y_clamp = clamp(req_y_sample);

   // branch select for the axis being worked on
   assign s_sel    = (dp_cmd.axis == AXIS_Y) ? y_s_ff    : x_s_ff;
   assign low_sel  = (dp_cmd.axis == AXIS_Y) ? y_low_ff  : x_low_ff;
   assign high_sel = (dp_cmd.axis == AXIS_Y) ? y_high_ff : x_high_ff;

   assign s_plus_m  = EW'(s_sel) + EW'(margin_ff);
   assign edge_sum  = EW'(high_sel) + EW'(margin_ff);
   assign low_minus = EW'(low_sel) - EW'(margin_ff);
   assign hi_span   = EW'(FULL) - edge_sum;
   assign hi_off    = EW'(s_sel) - edge_sum;
   assign lo_hit    = s_plus_m < EW'(low_sel);
   assign hi_hit    = EW'(s_sel) > edge_sum;
   assign lo_num    = NW'(s_sel) * NW'(LOW_SCALE);
   assign hi_num    = NW'(hi_off[SW-1:0]) * NW'(HIGH_SCALE);

   // restoring step; quotient < 8 so three steps from bit 2 down suffice
   assign trial = NW'(den_ff) << dp_cmd.shift;
   assign ge    = rem_ff >= trial;

   always_comb begin
      rem_in = rem_ff;
      den_in = den_ff;
      hi_in  = hi_ff;
      dz_in  = dz_ff;
      if (dp_cmd.setup) begin
         if (lo_hit) begin
            rem_in = lo_num;
            den_in = low_minus[SW-1:0];
            hi_in  = 1'b0;
            dz_in  = 1'b0;
         end else if (hi_hit) begin
            rem_in = hi_num;
            den_in = hi_span[SW-1:0];
            hi_in  = 1'b1;
            dz_in  = 1'b0;
         end else begin
            rem_in = '0;
            den_in = SW'(1);
            hi_in  = 1'b0;
            dz_in  = 1'b1;
         end
      end else if (dp_cmd.divide && ge) begin
         rem_in = rem_ff - trial;
      end
   end

   assign code = dz_ff ? DEAD_CODE : {hi_ff, quo_ff};

   // payload registers
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      hi_ff  <= hi_in;
      dz_ff  <= dz_in;
      if (dp_cmd.divide) begin
         quo_ff <= {quo_ff[QUO_W-2:0], ge};
      end
      if (dp_cmd.capture) begin
         x_s_ff <= x_clamp;
         y_s_ff <= y_clamp;
      end
      if (dp_cmd.store) begin
         if (dp_cmd.axis == AXIS_Y) begin
            y_code_ff <= code;
         end else begin
            x_code_ff <= code;
         end
      end
      if (dp_cmd.emit) begin
         rsp_packed_code_ff <= {y_code_ff, x_code_ff};
      end
   end

   // architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         margin_ff <= MARGIN_RESET;
         x_low_ff  <= FULL;
         x_high_ff <= '0;
         y_low_ff  <= FULL;
         y_high_ff <= '0;
         prev_x_ff <= '0;
         prev_y_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            margin_ff <= csr_wr_data;
         end
         if (dp_cmd.calibrate) begin
            if (x_clamp > x_high_ff) x_high_ff <= x_clamp;
            if (x_clamp < x_low_ff)  x_low_ff  <= x_clamp;
            if (y_clamp > y_high_ff) y_high_ff <= y_clamp;
            if (y_clamp < y_low_ff)  y_low_ff  <= y_clamp;
         end
         if (dp_cmd.emit) begin
            prev_x_ff <= x_code_ff;
            prev_y_ff <= y_code_ff;
         end
      end
   end

   assign dp_status.changed = (x_code_ff != prev_x_ff) || (y_code_ff != prev_y_ff);
   assign rsp_packed_code   = rsp_packed_code_ff;

endmodule

[rtl/joystick_deadzone_quantizer_top.sv]
// ============================================================================
// joystick_deadzone_quantizer_top
// Dead-zone quantizer for a two-axis joystick, 4-bit code per axis.
// ============================================================================
// Usage:
//  - req channel (valid/ready): one word = cmd, x_sample, y_sample.
//    cmd = 0 is a calibration word: it widens each axis' rest band (min/max)
//    and is absorbed in the accept cycle, so calibration words go at one per
//    cycle while the block is idle and never produce a response.
//  - cmd = 1 is a run word: each axis is quantized in turn by one shared
//    restoring divider (3 quotient bits, one per cycle). A run word keeps
//    the block busy through setup, 3 divide steps and a store per axis,
//    then the decide state. rsp_valid is registered from the decide emit.
//  - rsp channel (valid/ready): packed_code = {y_code, x_code}, sent only
//    when either code differs from the previous run word's codes.
//  - The response sits in an output register; the block takes the next word
//    while it waits. Only a second changed result stalls (in the decide
//    cycle) until rsp_ready frees the register.
//  - csr port: csr_wr_en writes dead_margin at once; write it only while idle.
//  - Reset (sync, active high): margin = 50, bands empty (low = full scale,
//    high = 0), previous codes 0/0, no response pending.
// ============================================================================
module joystick_deadzone_quantizer_top #(
   parameter int ADC_BITS = 12
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_cmd,
   input  logic [jdq_pkg::SAMPLE_W-1:0] req_x_sample,
   input  logic [jdq_pkg::SAMPLE_W-1:0] req_y_sample,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [jdq_pkg::PACK_W-1:0]   rsp_packed_code,
   input  logic                         csr_wr_en,
   input  logic [jdq_pkg::MARGIN_W-1:0] csr_wr_data
);
   import jdq_pkg::*;

   jdq_cmd_type    dp_cmd;
   jdq_status_type dp_status;

   // sequencer: owns both handshakes and the divide step count
   jdq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_cmd   (req_cmd),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .dp_cmd    (dp_cmd),
      .dp_status (dp_status)
   );

   // bands, margin, divider and code registers
   jdq_datapath #(
      .ADC_BITS (ADC_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .dp_cmd          (dp_cmd),
      .req_x_sample    (req_x_sample),
      .req_y_sample    (req_y_sample),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .dp_status       (dp_status),
      .rsp_packed_code (rsp_packed_code)
   );

endmodule

[bench/tb.sv]
// ============================================================================
// tb: joystick dead-zone quantizer testbench
// Drives cal/run sample words through the req channel with random gaps,
// keeps an independent model of the rest bands and the last codes, and checks
// every packed code on the rsp channel against that model, in order.
// ============================================================================
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import jdq_pkg::*;

   localparam int          ADC_BITS      = 12;
   localparam int unsigned FULL_SCALE    = (1 << ADC_BITS) - 1;
   localparam logic [3:0]  HIGH_BASE     = 4'd8;   // first code above the dead zone
   localparam int          SETTLE_CYCLES = 20;     // settle wait covering a run word's tail
   localparam int          STALL_LIMIT   = 2000;   // cycles with no handshake at all
   localparam int          PHASE_WORDS   = 150;

   typedef struct packed {
      logic                cmd;
      logic [SAMPLE_W-1:0] x;
      logic [SAMPLE_W-1:0] y;
   } sample_word_type;

   logic                clock           = 1'b0;
   logic                reset           = 1'b1;
   logic                req_valid       = 1'b0;
   logic                req_ready;
   logic                req_cmd         = CMD_CAL;
   logic [SAMPLE_W-1:0] req_x_sample    = '0;
   logic [SAMPLE_W-1:0] req_y_sample    = '0;
   logic                rsp_valid;
   logic                rsp_ready       = 1'b0;
   logic [PACK_W-1:0]   rsp_packed_code;
   logic                csr_wr_en       = 1'b0;
   logic [MARGIN_W-1:0] csr_wr_data     = '0;

   // words waiting for the driver, packed codes waiting for the monitor
   sample_word_type   word_q[$];
   logic [PACK_W-1:0] code_q[$];

   // shadow of the block: margin, rest bands, codes of the last run word
   int unsigned margin = 32'(MARGIN_RESET);
   int unsigned x_lo   = FULL_SCALE;
   int unsigned x_hi   = 0;
   int unsigned y_lo   = FULL_SCALE;
   int unsigned y_hi   = 0;
   logic [3:0]  last_x = '0;
   logic [3:0]  last_y = '0;

   sample_word_type repeat_word = '{cmd: CMD_RUN, x: 12'd2048, y: 12'd2048};
   logic            steady      = 1'b0;   // no gaps on either side while set
   int              errors      = 0;
   int              quiet       = 0;

   joystick_deadzone_quantizer_top #(
      .ADC_BITS(ADC_BITS)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cmd        (req_cmd),
      .req_x_sample   (req_x_sample),
      .req_y_sample   (req_y_sample),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_packed_code(rsp_packed_code),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // 4-bit code of one axis. Sums and differences are done in 32 bits, so a
   // margin reaching past either end of the range just disables that branch.
   function automatic logic [3:0] axis_code(int unsigned s, int unsigned lo,
                                            int unsigned hi, int unsigned m);
      int unsigned rim;
      if (s + m < lo) begin
         return 4'((s * LOW_SCALE) / (lo - m));
      end
      rim = hi + m;
      if (s > rim) begin
         return 4'(((s - rim) * HIGH_SCALE) / (FULL_SCALE - rim)) + HIGH_BASE;
      end
      return DEAD_CODE;
   endfunction

   // Apply one accepted word to the shadow; queue a code if the pair changed.
   function automatic void track_word(logic cmd, logic [SAMPLE_W-1:0] xs,
                                      logic [SAMPLE_W-1:0] ys);
      logic [3:0] xc;
      logic [3:0] yc;
      if (cmd == CMD_CAL) begin
         // cal word: band only ever widens, codes untouched
         if (xs > x_hi) x_hi = 32'(xs);
         if (xs < x_lo) x_lo = 32'(xs);
         if (ys > y_hi) y_hi = 32'(ys);
         if (ys < y_lo) y_lo = 32'(ys);
         return;
      end
      xc = axis_code(32'(xs), x_lo, x_hi, margin);
      yc = axis_code(32'(ys), y_lo, y_hi, margin);
      if (xc != last_x || yc != last_y) begin
         last_x = xc;
         last_y = yc;
         code_q.push_back({yc, xc});
      end
   endfunction

   // ---------------------------------------------------------------------
   // Driver: presents the next queued word, holds it until taken, and
   // feeds each taken word to the shadow at the same edge.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : drive
      sample_word_type w;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            track_word(req_cmd, req_x_sample, req_y_sample);
         end
         // free to move on when nothing is held or the held word just went
         if (!req_valid || req_ready) begin
            if (word_q.size() != 0 && (steady || $urandom_range(99) >= 35)) begin
               w = word_q.pop_front();
               req_valid    <= 1'b1;
               req_cmd      <= w.cmd;
               req_x_sample <= w.x;
               req_y_sample <= w.y;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: random back-pressure, in-order compare against code_q.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : watch
      logic [PACK_W-1:0] want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (code_q.size() == 0) begin
               if (errors < 10) begin
                  $display("%0t: unexpected packed code %h", $realtime, rsp_packed_code);
               end
               errors++;
            end else begin
               want = code_q.pop_front();
               if (rsp_packed_code !== want) begin
                  if (errors < 10) begin
                     $display("%0t: packed code expected %h got %h",
                              $realtime, want, rsp_packed_code);
                  end
                  errors++;
               end
            end
         end
         rsp_ready <= steady || ($urandom_range(99) >= 35);
      end
   end

   // Watchdog: any handshake on either channel counts as progress.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet <= 0;
      end else if (quiet >= STALL_LIMIT) begin
         $display("[joystick_deadzone_quantizer_top] ERROR");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   task automatic push_word(logic cmd, int unsigned xs, int unsigned ys);
      word_q.push_back('{cmd: cmd, x: SAMPLE_W'(xs), y: SAMPLE_W'(ys)});
   endtask

   // Random words. Cal words stay near mid-scale so they alone keep the bands
   // narrow and all code regions reachable.
   task automatic load_words(int count);
      sample_word_type w;
      int              pick;
      repeat (count) begin
         pick  = $urandom_range(99);
         w.cmd = CMD_RUN;
         w.x   = SAMPLE_W'($urandom_range(FULL_SCALE));
         w.y   = SAMPLE_W'($urandom_range(FULL_SCALE));
         if (pick < 12) begin
            w.cmd = CMD_CAL;
            w.x   = SAMPLE_W'($urandom_range(2110, 1990));
            w.y   = SAMPLE_W'($urandom_range(2100, 1980));
         end else if (pick < 30) begin
            w = repeat_word;            // same samples, usually no new code
         end else if (pick < 48) begin
            w.x = SAMPLE_W'($urandom_range(2400, 1700));
            w.y = SAMPLE_W'($urandom_range(2400, 1700));
         end else if (pick < 56) begin
            w.x = $urandom_range(1) ? SAMPLE_W'(FULL_SCALE) : '0;
            w.y = $urandom_range(1) ? SAMPLE_W'(FULL_SCALE) : '0;
         end
         if (w.cmd == CMD_RUN) begin
            repeat_word = w;
         end
         word_q.push_back(w);
      end
   endtask

   // Block idle: queue empty, last word taken, no code pending, plus the
   // tail of a run word that ends without a code.
   task automatic drain();
      while (word_q.size() != 0 || req_valid || code_q.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_margin(logic [MARGIN_W-1:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      margin = 32'(value);
      @(negedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Sequence: directed words at the reset margin, then random phases with
   // different margins, then a phase where the x band is blown wide open.
   // ---------------------------------------------------------------------
   initial begin
      logic [MARGIN_W-1:0] m;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // no calibration yet: empty bands, margin 50
      push_word(CMD_RUN, 0, 0);                    // codes 0/0 match reset: silent
      push_word(CMD_RUN, FULL_SCALE, FULL_SCALE);
      push_word(CMD_RUN, FULL_SCALE, 0);
      push_word(CMD_RUN, 2000, 1000);
      push_word(CMD_RUN, 2000, 1000);              // unchanged: silent
      push_word(CMD_RUN, FULL_SCALE - 1, 1);
      // rest band x 2040..2060, y 2030..2050
      push_word(CMD_CAL, 2040, 2030);
      push_word(CMD_CAL, 2060, 2050);
      push_word(CMD_CAL, 2050, 2040);
      push_word(CMD_RUN, 2048, 2048);
      push_word(CMD_RUN, 1989, 1979);              // one below low edge minus margin
      push_word(CMD_RUN, 1990, 1980);              // exactly on it: dead zone
      push_word(CMD_RUN, 2110, 2100);              // on high edge plus margin
      push_word(CMD_RUN, 2111, 2101);              // one above
      push_word(CMD_RUN, FULL_SCALE, FULL_SCALE);
      push_word(CMD_RUN, 0, 0);
      push_word(CMD_RUN, 0, FULL_SCALE);
      push_word(CMD_RUN, FULL_SCALE, 0);
      push_word(CMD_RUN, 2048, 2048);
      push_word(CMD_CAL, 2048, 2048);              // cal between equal runs
      push_word(CMD_RUN, 2048, 2048);              // codes kept: silent
      drain();

      for (int p = 0; p < 6; p++) begin
         case (p)
            0: m = '1;
            1: m = '0;
            3: m = MARGIN_W'(1);
            4: m = MARGIN_RESET;
            default: m = MARGIN_W'($urandom_range(1023));
         endcase
         set_margin(m);
         steady = (p == 2);   // one long stretch with no gaps at all
         load_words(PHASE_WORDS);
         drain();
      end
      steady = 1'b0;

      // x band opened to full scale and margin past both ends: x is stuck in
      // the dead zone, y band 1500..2600 still moves
      set_margin('1);
      push_word(CMD_CAL, 0, 1500);
      push_word(CMD_CAL, FULL_SCALE, 2600);
      load_words(PHASE_WORDS);
      drain();

      if (code_q.size() != 0) begin
         $display("%0d packed codes never arrived", code_q.size());
         errors += code_q.size();
      end
      if (errors == 0) begin
         $display("[joystick_deadzone_quantizer_top] OK");
      end else begin
         $display("[joystick_deadzone_quantizer_top] ERROR");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+rtl
rtl/jdq_pkg.sv
rtl/jdq_ctrl.sv
rtl/jdq_datapath.sv
rtl/joystick_deadzone_quantizer_top.sv
bench/tb.sv
